// File: design/cmfuv_pkg.sv
// ============================================================================
// Cube map face UV package
// Shared defaults and face codes for the cube map face and coordinate core.
// ============================================================================
`default_nettype none

package cmfuv_pkg;

    localparam int COMPONENT_BITS_DEFAULT = 16;
    localparam int UV_FRAC_BITS_DEFAULT   = 15;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

endpackage

`default_nettype wire

// File: design/cmfuv_div_step.sv
// ============================================================================
// Cube map face UV division step
// One restoring division step: compare the partial remainder with the
// divisor, produce one quotient bit and the reduced remainder.
// ============================================================================
`default_nettype none

module cmfuv_div_step #(
    parameter int REM_BITS = cmfuv_pkg::COMPONENT_BITS_DEFAULT + 1
) (
    input  logic [REM_BITS-1:0] rem_in,
    input  logic [REM_BITS-1:0] divisor,
    output logic                quo_bit,
    output logic [REM_BITS-1:0] rem_out
);

    always_comb
    begin
        quo_bit = (rem_in >= divisor);
        rem_out = quo_bit ? (rem_in - divisor) : rem_in;
    end

endmodule

`default_nettype wire

// File: design/cube_map_face_uv_core.sv
// ============================================================================
// Cube map face UV core
// Selects the cube face of a ray direction and computes its texture
// coordinates in unsigned fixed point.
// ============================================================================
// The core accepts one direction per clock unless a stall reaches its input,
// and returns one result per direction, in order. The pipeline holds the
// coordinate divider, which resolves one quotient bit per pipeline stage
// for UV_FRAC_BITS + 2 stages, plus an input stage, a face selection stage,
// an offset stage and the rounding output stage. Each stage holds its
// transaction on a stall and empty stages are filled while later ones
// wait.
`default_nettype none

module cube_map_face_uv_core #(
    parameter int COMPONENT_BITS = cmfuv_pkg::COMPONENT_BITS_DEFAULT,
    parameter int UV_FRAC_BITS   = cmfuv_pkg::UV_FRAC_BITS_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // Fields from bit 0 up: dir_x, dir_y, dir_z.
    input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // Fields from bit 0 up: face, tex_u, tex_v.
    output logic [((2*UV_FRAC_BITS+5+7)/8)*8-1:0]      m_axis_tdata,
    // Fields from bit 0 up: degenerate.
    output logic [0:0]                                 m_axis_tuser
);

    localparam int W     = COMPONENT_BITS;
    localparam int F     = UV_FRAC_BITS;
    localparam int D     = F + 2;
    localparam int NST   = D + 4;
    localparam int OUT_W = ((2*F+5+7)/8)*8;

    localparam logic [D-1:0] UV_ONE_Q  = {{(D-1){1'b0}}, 1'b1} << F;
    localparam logic [F:0]   UV_ONE    = {{F{1'b0}}, 1'b1} << F;
    localparam logic [F:0]   UV_HALF   = {{F{1'b0}}, 1'b1} << (F-1);

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] stage_en;
    logic [NST-1:0] valid_in;

    assign stage_en[NST-1] = !valid_reg[NST-1] || m_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < NST-1; gi++)
        begin : g_en
            assign stage_en[gi] = !valid_reg[gi] || stage_en[gi+1];
        end
    endgenerate

    assign valid_in      = {valid_reg[NST-2:0], s_axis_tvalid};
    assign s_axis_tready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    // Input stage.
    logic [W-1:0] x0_reg, y0_reg, z0_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            x0_reg <= s_axis_tdata[W-1:0];
            y0_reg <= s_axis_tdata[2*W-1:W];
            z0_reg <= s_axis_tdata[3*W-1:2*W];
        end
    end

    // Face selection stage.
    logic [W-1:0] ax, ay, az;
    logic [W:0]   xe, ye, ze, xn, yn, zn;
    logic         x_pos, y_pos, z_pos;
    logic [2:0]   face1_next;
    logic [W-1:0] m1_next;
    logic [W:0]   nu1_next, nv1_next;
    logic         degen1_next;

    always_comb
    begin
        xe    = {x0_reg[W-1], x0_reg};
        ye    = {y0_reg[W-1], y0_reg};
        ze    = {z0_reg[W-1], z0_reg};
        xn    = ~xe + 1'b1;
        yn    = ~ye + 1'b1;
        zn    = ~ze + 1'b1;
        ax    = x0_reg[W-1] ? xn[W-1:0] : x0_reg;
        ay    = y0_reg[W-1] ? yn[W-1:0] : y0_reg;
        az    = z0_reg[W-1] ? zn[W-1:0] : z0_reg;
        x_pos = !x0_reg[W-1] && (x0_reg != '0);
        y_pos = !y0_reg[W-1] && (y0_reg != '0);
        z_pos = !z0_reg[W-1] && (z0_reg != '0);
        degen1_next = (x0_reg == '0) && (y0_reg == '0) && (z0_reg == '0);

        priority if ((ax >= ay) && (ax >= az))
        begin
            m1_next    = ax;
            face1_next = x_pos ? cmfuv_pkg::FACE_POS_X : cmfuv_pkg::FACE_NEG_X;
            nu1_next   = x_pos ? ze : zn;
            nv1_next   = yn;
        end
        else if (ay >= az)
        begin
            m1_next    = ay;
            face1_next = y_pos ? cmfuv_pkg::FACE_POS_Y : cmfuv_pkg::FACE_NEG_Y;
            nu1_next   = xn;
            nv1_next   = y_pos ? ze : zn;
        end
        else
        begin
            m1_next    = az;
            face1_next = z_pos ? cmfuv_pkg::FACE_POS_Z : cmfuv_pkg::FACE_NEG_Z;
            nu1_next   = z_pos ? xn : xe;
            nv1_next   = yn;
        end
    end

    logic [2:0]   face1_reg;
    logic [W-1:0] m1_reg;
    logic [W:0]   nu1_reg, nv1_reg;
    logic         degen1_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            face1_reg  <= face1_next;
            m1_reg     <= m1_next;
            nu1_reg    <= nu1_next;
            nv1_reg    <= nv1_next;
            degen1_reg <= degen1_next;
        end
    end

    // Offset stage: the numerators m + n lie in [0, 2m].
    logic [2:0]   face2_reg;
    logic [W-1:0] m2_reg;
    logic [W:0]   su2_reg, sv2_reg;
    logic         degen2_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            face2_reg  <= face1_reg;
            m2_reg     <= m1_reg;
            su2_reg    <= {1'b0, m1_reg} + nu1_reg;
            sv2_reg    <= {1'b0, m1_reg} + nv1_reg;
            degen2_reg <= degen1_reg;
        end
    end

    // Division stages: quotient of s * 2^F / m, one bit per stage.
    logic [W:0]   rem_u_reg [D];
    logic [W:0]   rem_v_reg [D];
    logic [D-1:0] quo_u_reg [D];
    logic [D-1:0] quo_v_reg [D];
    logic [W-1:0] m_d_reg   [D];
    logic [2:0]   face_d_reg [D];
    logic         degen_d_reg [D];

    genvar gk;
    generate
        for (gk = 0; gk < D; gk++)
        begin : g_div
            logic [W:0]   rem_u_src, rem_v_src, div_src;
            logic [D-1:0] quo_u_src, quo_v_src;
            logic [W-1:0] m_src;
            logic [2:0]   face_src;
            logic         degen_src;
            logic         bit_u, bit_v;
            logic [W:0]   rem_u_new, rem_v_new;

            if (gk == 0)
            begin : g_first
                assign rem_u_src = su2_reg;
                assign rem_v_src = sv2_reg;
                assign div_src   = {m2_reg, 1'b0};
                assign quo_u_src = '0;
                assign quo_v_src = '0;
                assign m_src     = m2_reg;
                assign face_src  = face2_reg;
                assign degen_src = degen2_reg;
            end
            else
            begin : g_next
                if (gk == 1)
                begin : g_noshift
                    assign rem_u_src = rem_u_reg[gk-1];
                    assign rem_v_src = rem_v_reg[gk-1];
                end
                else
                begin : g_shift
                    assign rem_u_src = {rem_u_reg[gk-1][W-1:0], 1'b0};
                    assign rem_v_src = {rem_v_reg[gk-1][W-1:0], 1'b0};
                end
                assign div_src   = {1'b0, m_d_reg[gk-1]};
                assign quo_u_src = quo_u_reg[gk-1];
                assign quo_v_src = quo_v_reg[gk-1];
                assign m_src     = m_d_reg[gk-1];
                assign face_src  = face_d_reg[gk-1];
                assign degen_src = degen_d_reg[gk-1];
            end

            cmfuv_div_step #(
                .REM_BITS (W + 1)
            ) u_step_u (
                .rem_in  (rem_u_src),
                .divisor (div_src),
                .quo_bit (bit_u),
                .rem_out (rem_u_new)
            );

            cmfuv_div_step #(
                .REM_BITS (W + 1)
            ) u_step_v (
                .rem_in  (rem_v_src),
                .divisor (div_src),
                .quo_bit (bit_v),
                .rem_out (rem_v_new)
            );

            always_ff @(posedge clk)
            begin
                if (stage_en[3+gk])
                begin
                    rem_u_reg[gk]   <= rem_u_new;
                    rem_v_reg[gk]   <= rem_v_new;
                    quo_u_reg[gk]   <= {quo_u_src[D-2:0], bit_u};
                    quo_v_reg[gk]   <= {quo_v_src[D-2:0], bit_v};
                    m_d_reg[gk]     <= m_src;
                    face_d_reg[gk]  <= face_src;
                    degen_d_reg[gk] <= degen_src;
                end
            end
        end
    endgenerate

    // Rounding stage: round half up is (Q + 1) >> 1.
    logic [D:0]   qu_inc, qv_inc;
    logic [D-1:0] qu_rnd, qv_rnd;
    logic [F:0]   u_out_next, v_out_next;

    always_comb
    begin
        qu_inc = {1'b0, quo_u_reg[D-1]} + {{D{1'b0}}, 1'b1};
        qv_inc = {1'b0, quo_v_reg[D-1]} + {{D{1'b0}}, 1'b1};
        qu_rnd = qu_inc[D:1];
        qv_rnd = qv_inc[D:1];
        if (degen_d_reg[D-1])
        begin
            u_out_next = UV_HALF;
            v_out_next = UV_HALF;
        end
        else
        begin
            u_out_next = (qu_rnd > UV_ONE_Q) ? UV_ONE : qu_rnd[F:0];
            v_out_next = (qv_rnd > UV_ONE_Q) ? UV_ONE : qv_rnd[F:0];
        end
    end

    logic [2:0] face_out_reg;
    logic [F:0] u_out_reg, v_out_reg;
    logic       degen_out_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[NST-1])
        begin
            face_out_reg  <= face_d_reg[D-1];
            u_out_reg     <= u_out_next;
            v_out_reg     <= v_out_next;
            degen_out_reg <= degen_d_reg[D-1];
        end
    end

    assign m_axis_tvalid = valid_reg[NST-1];
    assign m_axis_tdata  = OUT_W'({v_out_reg, u_out_reg, face_out_reg});
    assign m_axis_tuser  = degen_out_reg;

endmodule

`default_nettype wire

// File: design/cmfuv_checker.sv
// ============================================================================
// Cube map face UV checker
// Port-level assertions for the cube map face and coordinate core.
// ============================================================================
`default_nettype none

module cmfuv_checker #(
    parameter int UV_FRAC_BITS   = cmfuv_pkg::UV_FRAC_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [((2*UV_FRAC_BITS+5+7)/8)*8-1:0] m_axis_tdata,
    input  logic [0:0]                            m_axis_tuser
);

    localparam int F = UV_FRAC_BITS;

    localparam logic [F:0] UV_ONE  = {{F{1'b0}}, 1'b1} << F;
    localparam logic [F:0] UV_HALF = {{F{1'b0}}, 1'b1} << (F-1);

    logic [2:0] face;
    logic [F:0] tex_u, tex_v;

    assign face    = m_axis_tdata[2:0];
    assign tex_u   = m_axis_tdata[F+3:3];
    assign tex_v   = m_axis_tdata[2*F+4:F+4];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("Stalled output transaction changed.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input not ready while the output is empty.");

    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (tex_u <= UV_ONE) && (tex_v <= UV_ONE)
        && (face <= cmfuv_pkg::FACE_NEG_Z))
        else $error("Output coordinate or face out of range.");

    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (face == cmfuv_pkg::FACE_NEG_X)
        && (tex_u == UV_HALF) && (tex_v == UV_HALF))
        else $error("Degenerate result has wrong face or coordinates.");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("Input stalled while the output was not blocked.");

    wire unused_in_valid = s_axis_tvalid;

endmodule

bind cube_map_face_uv_core cmfuv_checker #(
    .UV_FRAC_BITS   (UV_FRAC_BITS)
) u_cmfuv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
